### rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants for the cartridge bank switch and scanline IRQ
// block: bus address map, decode operations and result codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

    // Number of 1 KB character bank slots
    localparam int CHR_SLOTS_DEF = 8;
    // Width of a decoded character slot number
    localparam int DEC_SLOT_W    = 3;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Program slot update codes
    localparam logic [1:0] PRG_NONE = 2'd0;
    localparam logic [1:0] PRG_8000 = 2'd1;
    localparam logic [1:0] PRG_A000 = 2'd2;

    // Exact-match bus addresses
    localparam logic [15:0] ADDR_PRG0     = 16'h8000;
    localparam logic [15:0] ADDR_PRG0_ALT = 16'h8FFF;
    localparam logic [15:0] ADDR_PRG1     = 16'hA000;
    localparam logic [15:0] ADDR_PRG1_ALT = 16'hAFFF;
    localparam logic [15:0] ADDR_MIRROR0  = 16'h9000;
    localparam logic [15:0] ADDR_MIRROR1  = 16'h9004;
    localparam logic [15:0] ADDR_MIRROR2  = 16'h9008;
    localparam logic [15:0] ADDR_IRQ_LO   = 16'hF000;
    localparam logic [15:0] ADDR_IRQ_HI   = 16'hF004;
    localparam logic [15:0] ADDR_IRQ_CTRL = 16'hF008;
    localparam logic [15:0] ADDR_IRQ_ACK  = 16'hF00C;

    // Character group range (address bits 15:12)
    localparam logic [3:0] CHR_GROUP_FIRST = 4'hB;
    localparam logic [3:0] CHR_GROUP_LAST  = 4'hE;

    // Offsets within a character group
    localparam logic [11:0] CHR_OFS_LO_A     = 12'h000;
    localparam logic [11:0] CHR_OFS_HI_A     = 12'h001;
    localparam logic [11:0] CHR_OFS_HI_A_ALT = 12'h004;
    localparam logic [11:0] CHR_OFS_LO_B     = 12'h002;
    localparam logic [11:0] CHR_OFS_LO_B_ALT = 12'h008;
    localparam logic [11:0] CHR_OFS_HI_B     = 12'h003;
    localparam logic [11:0] CHR_OFS_HI_B_ALT = 12'h00C;

    // Counter overflow value
    localparam logic [8:0] IRQ_WRAP = 9'd256;

    // Decoded operation for one item
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_PRG0,
        OP_PRG1,
        OP_MIRROR,
        OP_IRQ_LO,
        OP_IRQ_HI,
        OP_IRQ_CTRL,
        OP_IRQ_ACK,
        OP_CHR
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [DEC_SLOT_W-1:0] chr_slot;
        logic                  chr_high;
    } dec_t;

endpackage

`default_nettype wire

### rtl/cartridge_bank_switch_irq.sv
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while the receiver does not stall the output, set by the
// single-pass decode and state update between the two registers.
// Reset clears all character nibbles, the IRQ enable, repeat, counter and
// latch, and empties both register stages.
// ----------------------------------------------------------------------------
// cartridge_bank_switch_irq
// Bank switch mapper: decodes bus writes into program, mirroring and character
// bank updates, and runs a scanline IRQ counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_switch_irq #(
    parameter int CHR_SLOTS = cbs_pkg::CHR_SLOTS_DEF,
    localparam int SLOT_W   = $clog2(CHR_SLOTS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire logic [15:0]       address,
    input  wire logic [7:0]        data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             prg_slot_update,
    output logic [7:0]             prg_bank,
    output logic                   chr_update,
    output logic [SLOT_W-1:0]      chr_slot,
    output logic [7:0]             chr_bank,
    output logic                   mirror_update,
    output logic [1:0]             mirror_mode,
    output logic                   irq_pulse
);

    // Input stage
    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic [15:0]         s1_address_reg;
    logic [7:0]          s1_data_reg;
    logic                s1_advance;

    // Mapper state
    logic [3:0]          chr_lo_reg [CHR_SLOTS];
    logic [3:0]          chr_hi_reg [CHR_SLOTS];
    logic                irq_enable_reg, irq_enable_next;
    logic                irq_repeat_reg, irq_repeat_next;
    logic [8:0]          irq_count_reg, irq_count_next;
    logic [7:0]          irq_reload_reg, irq_reload_next;

    // Result stage
    logic                out_valid_reg;
    logic [1:0]          prg_slot_update_reg, prg_slot_update_next;
    logic [7:0]          prg_bank_reg, prg_bank_next;
    logic                chr_update_reg, chr_update_next;
    logic [SLOT_W-1:0]   chr_slot_reg, chr_slot_next;
    logic [7:0]          chr_bank_reg, chr_bank_next;
    logic                mirror_update_reg, mirror_update_next;
    logic [1:0]          mirror_mode_reg, mirror_mode_next;
    logic                irq_pulse_reg, irq_pulse_next;

    cbs_pkg::dec_t       dec;
    logic [SLOT_W-1:0]   slot_idx;
    logic [3:0]          nib;
    logic [8:0]          count_inc;
    logic                chr_we_lo, chr_we_hi;

    // Advance when the result register is empty or being drained
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Hold the payload of the item in the input stage
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg    <= kind;
            s1_address_reg <= address;
            s1_data_reg    <= data;
        end
    end

    cbs_decode u_decode (
        .kind    (s1_kind_reg),
        .address (s1_address_reg),
        .dec     (dec)
    );

    assign slot_idx  = dec.chr_slot[SLOT_W-1:0];
    assign nib       = s1_data_reg[3:0];
    assign count_inc = irq_count_reg + 9'd1;

    // Compute results and next IRQ state for the item in the input stage
    always_comb
    begin
        prg_slot_update_next = cbs_pkg::PRG_NONE;
        prg_bank_next        = '0;
        chr_update_next      = 1'b0;
        chr_slot_next        = '0;
        chr_bank_next        = '0;
        mirror_update_next   = 1'b0;
        mirror_mode_next     = '0;
        irq_pulse_next       = 1'b0;
        irq_enable_next      = irq_enable_reg;
        irq_repeat_next      = irq_repeat_reg;
        irq_count_next       = irq_count_reg;
        irq_reload_next      = irq_reload_reg;
        chr_we_lo            = 1'b0;
        chr_we_hi            = 1'b0;
        case (dec.op)
            cbs_pkg::OP_PRG0:
            begin
                prg_slot_update_next = cbs_pkg::PRG_8000;
                prg_bank_next        = s1_data_reg;
            end
            cbs_pkg::OP_PRG1:
            begin
                prg_slot_update_next = cbs_pkg::PRG_A000;
                prg_bank_next        = s1_data_reg;
            end
            cbs_pkg::OP_MIRROR:
            begin
                mirror_update_next = 1'b1;
                mirror_mode_next   = s1_data_reg[1:0];
            end
            cbs_pkg::OP_IRQ_LO:
            begin
                irq_reload_next = {irq_reload_reg[7:4], nib};
            end
            cbs_pkg::OP_IRQ_HI:
            begin
                irq_reload_next = {nib, irq_reload_reg[3:0]};
            end
            cbs_pkg::OP_IRQ_CTRL:
            begin
                irq_enable_next = s1_data_reg[1];
                irq_repeat_next = s1_data_reg[0];
                irq_count_next  = {1'b0, irq_reload_reg};
            end
            cbs_pkg::OP_IRQ_ACK:
            begin
                irq_enable_next = irq_repeat_reg;
            end
            cbs_pkg::OP_CHR:
            begin
                chr_update_next = 1'b1;
                chr_slot_next   = slot_idx;
                if (dec.chr_high)
                begin
                    chr_we_hi     = 1'b1;
                    chr_bank_next = {nib, chr_lo_reg[slot_idx]};
                end
                else
                begin
                    chr_we_lo     = 1'b1;
                    chr_bank_next = {chr_hi_reg[slot_idx], nib};
                end
            end
            cbs_pkg::OP_TICK:
            begin
                if (irq_enable_reg)
                begin
                    if (count_inc == cbs_pkg::IRQ_WRAP)
                    begin
                        irq_count_next  = {1'b0, irq_reload_reg};
                        irq_pulse_next  = 1'b1;
                        irq_enable_next = irq_repeat_reg;
                    end
                    else
                    begin
                        irq_count_next = count_inc;
                    end
                end
            end
            default:
            begin
                irq_count_next = irq_count_reg;
            end
        endcase
    end

    // Update mapper state as the item leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHR_SLOTS; i++)
            begin
                chr_lo_reg[i] <= '0;
                chr_hi_reg[i] <= '0;
            end
            irq_enable_reg <= 1'b0;
            irq_repeat_reg <= 1'b0;
            irq_count_reg  <= '0;
            irq_reload_reg <= '0;
        end
        else if (s1_advance)
        begin
            if (chr_we_lo)
            begin
                chr_lo_reg[slot_idx] <= nib;
            end
            if (chr_we_hi)
            begin
                chr_hi_reg[slot_idx] <= nib;
            end
            irq_enable_reg <= irq_enable_next;
            irq_repeat_reg <= irq_repeat_next;
            irq_count_reg  <= irq_count_next;
            irq_reload_reg <= irq_reload_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            prg_slot_update_reg <= prg_slot_update_next;
            prg_bank_reg        <= prg_bank_next;
            chr_update_reg      <= chr_update_next;
            chr_slot_reg        <= chr_slot_next;
            chr_bank_reg        <= chr_bank_next;
            mirror_update_reg   <= mirror_update_next;
            mirror_mode_reg     <= mirror_mode_next;
            irq_pulse_reg       <= irq_pulse_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign prg_slot_update = prg_slot_update_reg;
    assign prg_bank        = prg_bank_reg;
    assign chr_update      = chr_update_reg;
    assign chr_slot        = chr_slot_reg;
    assign chr_bank        = chr_bank_reg;
    assign mirror_update   = mirror_update_reg;
    assign mirror_mode     = mirror_mode_reg;
    assign irq_pulse       = irq_pulse_reg;

    // Interrupt results carry no bank or mirroring update
    a_irq_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_pulse |->
            prg_slot_update == cbs_pkg::PRG_NONE && !chr_update && !mirror_update)
        else $error("irq pulse together with a bank update");

    // Counter never rests at the wrap value
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !irq_count_reg[8])
        else $error("irq counter left at wrap value");

    // A stalled result blocks the input stage
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !s1_advance)
        else $error("input stage advanced into a stalled result");

    // No item enters while the input stage is full and stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid && !out_ready |-> !in_ready)
        else $error("item accepted over a held item");

endmodule

`default_nettype wire

### rtl/cbs_decode.sv
// ----------------------------------------------------------------------------
// cbs_decode
// Decodes one item (bus write or scanline tick) into an operation, plus the
// character slot and nibble half for character bank writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbs_decode (
    input  wire logic          kind,
    input  wire logic [15:0]   address,
    output cbs_pkg::dec_t      dec
);

    logic [3:0]  group;
    logic [1:0]  pair;

    assign group = address[15:12];
    assign pair  = 2'(group - cbs_pkg::CHR_GROUP_FIRST);

    // Match the address exactly, then fall back to the character groups
    always_comb
    begin
        dec.op       = cbs_pkg::OP_NONE;
        dec.chr_slot = '0;
        dec.chr_high = 1'b0;
        if (kind == cbs_pkg::KIND_TICK)
        begin
            dec.op = cbs_pkg::OP_TICK;
        end
        else
        begin
            case (address)
                cbs_pkg::ADDR_PRG0, cbs_pkg::ADDR_PRG0_ALT: dec.op = cbs_pkg::OP_PRG0;
                cbs_pkg::ADDR_PRG1, cbs_pkg::ADDR_PRG1_ALT: dec.op = cbs_pkg::OP_PRG1;
                cbs_pkg::ADDR_MIRROR0, cbs_pkg::ADDR_MIRROR1, cbs_pkg::ADDR_MIRROR2:
                    dec.op = cbs_pkg::OP_MIRROR;
                cbs_pkg::ADDR_IRQ_LO:   dec.op = cbs_pkg::OP_IRQ_LO;
                cbs_pkg::ADDR_IRQ_HI:   dec.op = cbs_pkg::OP_IRQ_HI;
                cbs_pkg::ADDR_IRQ_CTRL: dec.op = cbs_pkg::OP_IRQ_CTRL;
                cbs_pkg::ADDR_IRQ_ACK:  dec.op = cbs_pkg::OP_IRQ_ACK;
                default:
                begin
                    if (group inside {[cbs_pkg::CHR_GROUP_FIRST:cbs_pkg::CHR_GROUP_LAST]})
                    begin
                        case (address[11:0])
                            cbs_pkg::CHR_OFS_LO_A:
                            begin
                                dec.op       = cbs_pkg::OP_CHR;
                                dec.chr_slot = {pair, 1'b0};
                            end
                            cbs_pkg::CHR_OFS_HI_A, cbs_pkg::CHR_OFS_HI_A_ALT:
                            begin
                                dec.op       = cbs_pkg::OP_CHR;
                                dec.chr_slot = {pair, 1'b0};
                                dec.chr_high = 1'b1;
                            end
                            cbs_pkg::CHR_OFS_LO_B, cbs_pkg::CHR_OFS_LO_B_ALT:
                            begin
                                dec.op       = cbs_pkg::OP_CHR;
                                dec.chr_slot = {pair, 1'b1};
                            end
                            cbs_pkg::CHR_OFS_HI_B, cbs_pkg::CHR_OFS_HI_B_ALT:
                            begin
                                dec.op       = cbs_pkg::OP_CHR;
                                dec.chr_slot = {pair, 1'b1};
                                dec.chr_high = 1'b1;
                            end
                            default:
                            begin
                                dec.op = cbs_pkg::OP_NONE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### tb/cartridge_bank_switch_irq_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_switch_irq_test
// Drives CPU bus writes and scanline ticks into the mapper under random
// input gaps and output stalls. An in-bench model of the bank, mirroring and
// IRQ registers predicts every result, and each result is checked in order.
// ----------------------------------------------------------------------------

module cartridge_bank_switch_irq_test;

    import cbs_pkg::*;

    localparam int SLOTS        = 8;
    localparam int SLOT_BITS    = 3;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 250;
    localparam int BURST_ITEMS  = 48;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;

    // One result item as the block presents it
    typedef struct packed {
        logic [1:0]           prg_upd;
        logic [7:0]           prg_bank;
        logic                 chr_upd;
        logic [SLOT_BITS-1:0] chr_slot;
        logic [7:0]           chr_bank;
        logic                 mir_upd;
        logic [1:0]           mir_mode;
        logic                 irq;
    } mapper_result_t;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 in_valid        = 1'b0;
    logic                 in_ready;
    logic                 kind            = KIND_WRITE;
    logic [15:0]          address         = 16'h0000;
    logic [7:0]           data            = 8'h00;
    logic                 out_valid;
    logic                 out_ready       = 1'b0;
    logic [1:0]           prg_slot_update;
    logic [7:0]           prg_bank;
    logic                 chr_update;
    logic [SLOT_BITS-1:0] chr_slot;
    logic [7:0]           chr_bank;
    logic                 mirror_update;
    logic [1:0]           mirror_mode;
    logic                 irq_pulse;

    // Mapper model state
    logic [3:0] chr_lo [SLOTS] = '{default: 4'h0};
    logic [3:0] chr_hi [SLOTS] = '{default: 4'h0};
    logic       irq_en    = 1'b0;
    logic       irq_rep   = 1'b0;
    logic [8:0] irq_cnt   = 9'd0;
    logic [7:0] irq_latch = 8'h00;

    logic [11:0] chr_ofs_list [7] = '{CHR_OFS_LO_A, CHR_OFS_HI_A, CHR_OFS_HI_A_ALT,
                                      CHR_OFS_LO_B, CHR_OFS_LO_B_ALT, CHR_OFS_HI_B,
                                      CHR_OFS_HI_B_ALT};

    mapper_result_t pending_results [$];
    int             fail_count  = 0;
    int             cycle_count = 0;
    int             rx_hold     = 0;
    bit             rx_stall_en = 1'b1;
    bit             tx_gap_en   = 1'b1;

    cartridge_bank_switch_irq #(.CHR_SLOTS(SLOTS)) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .address         (address),
        .data            (data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .prg_slot_update (prg_slot_update),
        .prg_bank        (prg_bank),
        .chr_update      (chr_update),
        .chr_slot        (chr_slot),
        .chr_bank        (chr_bank),
        .mirror_update   (mirror_update),
        .mirror_mode     (mirror_mode),
        .irq_pulse       (irq_pulse)
    );

    always #6 clk = ~clk;

    // Advance the mapper model by one item and return its result
    function automatic mapper_result_t mapper_predict(input logic k, input logic [15:0] a,
                                                      input logic [7:0] d);
        mapper_result_t       r;
        logic [3:0]           grp;
        logic [11:0]          ofs;
        logic [SLOT_BITS-1:0] slot;
        logic                 hi;
        logic                 hit;
        r    = '0;
        hit  = 1'b0;
        hi   = 1'b0;
        slot = '0;
        if (k == KIND_TICK)
        begin
            if (irq_en)
            begin
                irq_cnt = irq_cnt + 9'd1;
                if (irq_cnt == IRQ_WRAP)
                begin
                    irq_cnt = {1'b0, irq_latch};
                    r.irq   = 1'b1;
                    irq_en  = irq_rep;
                end
            end
        end
        else
        begin
            case (a)
                ADDR_PRG0, ADDR_PRG0_ALT:
                begin
                    r.prg_upd  = PRG_8000;
                    r.prg_bank = d;
                end
                ADDR_PRG1, ADDR_PRG1_ALT:
                begin
                    r.prg_upd  = PRG_A000;
                    r.prg_bank = d;
                end
                ADDR_MIRROR0, ADDR_MIRROR1, ADDR_MIRROR2:
                begin
                    r.mir_upd  = 1'b1;
                    r.mir_mode = d[1:0];
                end
                ADDR_IRQ_LO:   irq_latch[3:0] = d[3:0];
                ADDR_IRQ_HI:   irq_latch[7:4] = d[3:0];
                ADDR_IRQ_CTRL:
                begin
                    irq_en  = d[1];
                    irq_rep = d[0];
                    irq_cnt = {1'b0, irq_latch};
                end
                ADDR_IRQ_ACK:  irq_en = irq_rep;
                default:
                begin
                    // Character groups hold two slots each, several offsets alias
                    grp = a[15:12];
                    ofs = a[11:0];
                    if (grp >= CHR_GROUP_FIRST && grp <= CHR_GROUP_LAST)
                    begin
                        slot = SLOT_BITS'((grp - CHR_GROUP_FIRST) << 1);
                        case (ofs)
                            CHR_OFS_LO_A: hit = 1'b1;
                            CHR_OFS_HI_A, CHR_OFS_HI_A_ALT:
                            begin
                                hit = 1'b1;
                                hi  = 1'b1;
                            end
                            CHR_OFS_LO_B, CHR_OFS_LO_B_ALT:
                            begin
                                hit  = 1'b1;
                                slot = slot + 1'b1;
                            end
                            CHR_OFS_HI_B, CHR_OFS_HI_B_ALT:
                            begin
                                hit  = 1'b1;
                                hi   = 1'b1;
                                slot = slot + 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    if (hit)
                    begin
                        if (hi)
                            chr_hi[slot] = d[3:0];
                        else
                            chr_lo[slot] = d[3:0];
                        r.chr_upd  = 1'b1;
                        r.chr_slot = slot;
                        r.chr_bank = {chr_hi[slot], chr_lo[slot]};
                    end
                end
            endcase
        end
        return r;
    endfunction

    // Pick an idle gap before the next item: mostly none, a few long
    function automatic int pick_gap();
        int r;
        if (!tx_gap_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item and hold it until accepted; ends on a falling edge
    task automatic offer_item(input logic k, input logic [15:0] a, input logic [7:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind     = k;
        address  = a;
        data     = d;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(mapper_predict(k, a, d));
        @(negedge clk);
    endtask

    // Build one random item, mostly decodable writes and ticks, some noise
    task automatic random_item();
        int          r;
        logic        k;
        logic [15:0] a;
        logic [7:0]  d;
        r = $urandom_range(0, 99);
        k = KIND_WRITE;
        d = 8'($urandom);
        a = 16'($urandom);
        if (r < 30)
            k = KIND_TICK;
        else if (r < 38)
        begin
            case ($urandom_range(0, 3))
                0:       a = ADDR_PRG0;
                1:       a = ADDR_PRG0_ALT;
                2:       a = ADDR_PRG1;
                default: a = ADDR_PRG1_ALT;
            endcase
        end
        else if (r < 44)
        begin
            case ($urandom_range(0, 2))
                0:       a = ADDR_MIRROR0;
                1:       a = ADDR_MIRROR1;
                default: a = ADDR_MIRROR2;
            endcase
        end
        else if (r < 64)
            a = {4'($urandom_range(CHR_GROUP_FIRST, CHR_GROUP_LAST)),
                 chr_ofs_list[$urandom_range(0, 6)]};
        else if (r < 70)
            a = ADDR_IRQ_LO;
        else if (r < 76)
        begin
            // Bias the latch high so the counter overflows often
            a = ADDR_IRQ_HI;
            if ($urandom_range(0, 9) < 6)
                d[3:0] = 4'hF;
        end
        else if (r < 82)
        begin
            a = ADDR_IRQ_CTRL;
            if ($urandom_range(0, 3) != 0)
                d[1] = 1'b1;
        end
        else if (r < 86)
            a = ADDR_IRQ_ACK;
        else if (r < 92)
            k = 1'($urandom);
        else if (r < 96)
            a = {4'($urandom_range(CHR_GROUP_FIRST, CHR_GROUP_LAST)),
                 12'($urandom_range(0, 15))};
        else
            a = {12'hF00, 4'($urandom)};
        offer_item(k, a, d);
    endtask

    // Tick while disabled and unlisted addresses
    task automatic test_unlisted_and_idle_tick();
        offer_item(KIND_TICK, 16'h0000, 8'h00);
        offer_item(KIND_WRITE, 16'h0000, 8'hFF);
        offer_item(KIND_WRITE, 16'hFFFF, 8'h00);
    endtask

    // Program bank selects and every mirroring address
    task automatic test_program_and_mirror();
        offer_item(KIND_WRITE, ADDR_PRG0, 8'h00);
        offer_item(KIND_WRITE, ADDR_PRG0_ALT, 8'hFF);
        offer_item(KIND_WRITE, ADDR_PRG1, 8'hA5);
        offer_item(KIND_WRITE, ADDR_PRG1_ALT, 8'h5A);
        offer_item(KIND_WRITE, ADDR_MIRROR0, 8'hFF);
        offer_item(KIND_WRITE, ADDR_MIRROR1, 8'h01);
        offer_item(KIND_WRITE, ADDR_MIRROR2, 8'h02);
    endtask

    // Every character offset form, across all four groups
    task automatic test_chr_halves();
        offer_item(KIND_WRITE, 16'hB000, 8'hFF);
        offer_item(KIND_WRITE, 16'hB004, 8'hF0);
        offer_item(KIND_WRITE, 16'hC001, 8'h0F);
        offer_item(KIND_WRITE, 16'hC008, 8'hA9);
        offer_item(KIND_WRITE, 16'hD002, 8'h03);
        offer_item(KIND_WRITE, 16'hD003, 8'h0C);
        offer_item(KIND_WRITE, 16'hE00C, 8'hFF);
    endtask

    // Counter overflow with repeat, acknowledge, and one-shot mode
    task automatic test_irq_counter();
        offer_item(KIND_WRITE, ADDR_IRQ_LO, 8'hFE);
        offer_item(KIND_WRITE, ADDR_IRQ_HI, 8'hFF);
        offer_item(KIND_WRITE, ADDR_IRQ_CTRL, 8'h03);
        offer_item(KIND_TICK, 16'hFFFF, 8'hFF);
        offer_item(KIND_TICK, 16'h0000, 8'h00);
        offer_item(KIND_WRITE, ADDR_IRQ_ACK, 8'h00);
        offer_item(KIND_WRITE, ADDR_IRQ_CTRL, 8'h02);
        offer_item(KIND_TICK, 16'h0000, 8'h00);
        offer_item(KIND_TICK, 16'h0000, 8'h00);
        offer_item(KIND_TICK, 16'h0000, 8'h00);
    endtask

    // Back-to-back items with the receiver always ready
    task automatic test_streaming(input int count);
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        repeat (count) random_item();
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) random_item();
    endtask

    // Hold the receiver off so the block fills and stalls its input
    task automatic test_output_backpressure();
        rx_hold   = LONG_HOLD;
        tx_gap_en = 1'b0;
        repeat (BURST_ITEMS) random_item();
        tx_gap_en = 1'b1;
    endtask

    // Pause the sender until every outstanding result has come back
    task automatic test_drain_pause(input int count);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (count) random_item();
    endtask

    // Receiver: random stalls, plus a long hold-off when requested
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready = 1'b0;
                rx_hold   = rx_hold - 1;
            end
            else if (stall_left > 0)
            begin
                out_ready  = 1'b0;
                stall_left = stall_left - 1;
            end
            else if (rx_stall_en && $urandom_range(0, 99) < 25)
            begin
                out_ready  = 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                          : $urandom_range(0, 2);
            end
            else
                out_ready = 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        mapper_result_t got;
        mapper_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {prg_slot_update, prg_bank, chr_update, chr_slot, chr_bank,
                   mirror_update, mirror_mode, irq_pulse};
            if (pending_results.size() == 0)
            begin
                fail_count = fail_count + 1;
                if (fail_count <= REPORT_LIMIT)
                    $display("result with no item outstanding: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("want prg %0d/%02h chr %0d/%0d/%02h mir %0d/%0d irq %0d",
                                 want.prg_upd, want.prg_bank, want.chr_upd, want.chr_slot,
                                 want.chr_bank, want.mir_upd, want.mir_mode, want.irq);
                        $display("got  prg %0d/%02h chr %0d/%0d/%02h mir %0d/%0d irq %0d",
                                 got.prg_upd, got.prg_bank, got.chr_upd, got.chr_slot,
                                 got.chr_bank, got.mir_upd, got.mir_mode, got.irq);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cartridge_bank_switch_irq: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_unlisted_and_idle_tick();
        test_program_and_mirror();
        test_chr_halves();
        test_irq_counter();
        test_streaming(100);
        test_random_traffic(350);
        test_output_backpressure();
        test_drain_pause(50);
        test_random_traffic(400);

        // Drop valid and let the pipeline empty
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("cartridge_bank_switch_irq: match");
        else
            $display("cartridge_bank_switch_irq: mismatch");
        $finish;
    end

endmodule
